/* src/hds_pkg.sv */
// ---------------------------------------------------------------------------
// hds_pkg
// Shared constants, types and the arctangent table for the heading
// deviation sum unit.
// ---------------------------------------------------------------------------
package hds_pkg;

   // defaults for the top level parameters
   localparam int POS_BITS_DEF        = 16;
   localparam int ANGLE_FRAC_BITS_DEF = 6;
   localparam int ATAN_STEPS_DEF      = 16;

   // position difference is scaled up by this many bits before the cordic
   localparam int PRESCALE_BITS = 24;
   // headroom for the sign bit of the difference and cordic gain
   localparam int GROWTH_BITS   = 3;
   // integer bits of a heading word above its fraction bits
   localparam int HEAD_INT_BITS = 9;

   // cordic angle word: signed degrees with 32 fraction bits
   localparam int DEG_FRAC_BITS = 32;
   localparam int ANGLE_W       = 42;
   localparam int TABLE_LEN     = 32;
   localparam int TURN_DEG      = 360;
   localparam int HALF_DEG      = 180;

   typedef logic signed [ANGLE_W-1:0] angle_type;

   localparam angle_type HALF_TURN_Q32 = 42'sd773094113280;
   localparam angle_type FULL_TURN_Q32 = 42'sd1546188226560;

   // atan(2^-i) in degrees, 32 fraction bits
   localparam angle_type ATAN_TABLE [TABLE_LEN] = '{
      42'sd193273528320, 42'sd114096026022, 42'sd60285206653, 42'sd30601712202,
      42'sd15360239180,  42'sd7687607525,   42'sd3844741810,  42'sd1922488225,
      42'sd961258780,    42'sd480631223,    42'sd240315840,   42'sd120157949,
      42'sd60078978,     42'sd30039490,     42'sd15019745,    42'sd7509872,
      42'sd3754936,      42'sd1877468,      42'sd938734,      42'sd469367,
      42'sd234684,       42'sd117342,       42'sd58671,       42'sd29335,
      42'sd14668,        42'sd7334,         42'sd3667,        42'sd1833,
      42'sd917,          42'sd458,          42'sd229,         42'sd115
   };

endpackage

/* src/hds_cordic_stage.sv */
// ---------------------------------------------------------------------------
// hds_cordic_stage
// One registered vectoring step of the arctangent: rotates the vector
// towards the x axis by atan(2^-STEP) and accumulates the angle.
// ---------------------------------------------------------------------------
module hds_cordic_stage #(
   parameter int W    = 43,
   parameter int STEP = 0,
   parameter int SW   = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic signed [W-1:0]        in_x,
   input  logic signed [W-1:0]        in_y,
   input  hds_pkg::angle_type         in_z,
   input  logic [SW-1:0]              in_side,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [W-1:0]        out_x,
   output logic signed [W-1:0]        out_y,
   output hds_pkg::angle_type         out_z,
   output logic [SW-1:0]              out_side
);
   import hds_pkg::*;

   logic                valid_ff;
   logic                load;
   logic signed [W-1:0] x_ff, x_in;
   logic signed [W-1:0] y_ff, y_in;
   angle_type           z_ff, z_in;
   logic [SW-1:0]       side_ff;
   logic signed [W-1:0] x_shift, y_shift;

   // stage takes a word when empty or when the next one takes ours
   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   // vectoring step, direction from the sign of y
   always_comb begin
      x_shift = in_x >>> STEP;
      y_shift = in_y >>> STEP;
      if (!in_y[W-1]) begin
         x_in = in_x + y_shift;
         y_in = in_y - x_shift;
         z_in = in_z + ATAN_TABLE[STEP];
      end else begin
         x_in = in_x - y_shift;
         y_in = in_y + x_shift;
         z_in = in_z - ATAN_TABLE[STEP];
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

/* src/heading_deviation_sum_unit.sv */
// ---------------------------------------------------------------------------
// heading_deviation_sum_unit
// Bearing from one pose to the next by a pipelined cordic arctangent, and
// the sum of both headings' shorter-way deviations from that bearing.
// ---------------------------------------------------------------------------
// Usage
//   req channel: two poses (x, y, heading) per word, valid/ready handshake.
//   rsp channel: one total deviation per request word, same order.
//   Headings and the result are in 1/2^ANGLE_FRAC_BITS degree units.
// Pipeline: from request accept to response valid a word passes the
//   registers for difference, pre-rotation, one stage per cordic step,
//   angle offset, rounding, bearing wrap, folding and final sum.
// Throughput: one word per cycle; every stage is a register slice with
//   its own valid bit, so a new word enters each cycle the pipe moves.
// Stall: when rsp_ready is low the result holds on rsp; stages behind it
//   keep filling bubbles, and req_ready drops only when every stage
//   is full.
// Reset: synchronous, clears all valid bits; the pipe comes out empty and
//   ready for a request.
// ---------------------------------------------------------------------------
module heading_deviation_sum_unit #(
   parameter int POS_BITS        = hds_pkg::POS_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = hds_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int ATAN_STEPS      = hds_pkg::ATAN_STEPS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             req_valid,
   output logic                                             req_ready,
   input  logic signed [POS_BITS-1:0]                       req_start_x,
   input  logic signed [POS_BITS-1:0]                       req_start_y,
   input  logic [ANGLE_FRAC_BITS+hds_pkg::HEAD_INT_BITS-1:0] req_start_heading,
   input  logic signed [POS_BITS-1:0]                       req_end_x,
   input  logic signed [POS_BITS-1:0]                       req_end_y,
   input  logic [ANGLE_FRAC_BITS+hds_pkg::HEAD_INT_BITS-1:0] req_end_heading,
   output logic                                             rsp_valid,
   input  logic                                             rsp_ready,
   output logic [ANGLE_FRAC_BITS+hds_pkg::HEAD_INT_BITS-1:0] rsp_total_deviation
);
   import hds_pkg::*;

   localparam int HB  = ANGLE_FRAC_BITS + HEAD_INT_BITS;  // heading width
   localparam int DW  = POS_BITS + 1;                      // difference width
   localparam int CW  = POS_BITS + PRESCALE_BITS + GROWTH_BITS;
   localparam int SW  = 2 * HB + 2;                        // sideband width
   localparam int N   = ATAN_STEPS;
   localparam int RSH = DEG_FRAC_BITS - ANGLE_FRAC_BITS;   // rounding shift

   localparam logic [HB:0] FULL_TURN = (HB+1)'(TURN_DEG) << ANGLE_FRAC_BITS;
   localparam logic [HB:0] HALF_TURN = (HB+1)'(HALF_DEG) << ANGLE_FRAC_BITS;
   localparam logic [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1) << (RSH - 1);

   // ---------------- stage a: differences and heading reduction
   logic                 a_v_ff, a_load;
   logic signed [DW-1:0] a_dx_ff, a_dy_ff;
   logic [HB-1:0]        a_sh_ff, a_eh_ff, a_sh_in, a_eh_in;

   logic                 b_load;

   assign a_load    = !a_v_ff || b_load;
   assign req_ready = a_load;

   // one turn off a heading at or above a full turn
   always_comb begin
      a_sh_in = req_start_heading;
      a_eh_in = req_end_heading;
      if ({1'b0, req_start_heading} >= FULL_TURN) begin
         a_sh_in = HB'({1'b0, req_start_heading} - FULL_TURN);
      end
      if ({1'b0, req_end_heading} >= FULL_TURN) begin
         a_eh_in = HB'({1'b0, req_end_heading} - FULL_TURN);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (a_load) begin
         a_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load && req_valid) begin
         a_dx_ff <= DW'(req_end_x) - DW'(req_start_x);
         a_dy_ff <= DW'(req_end_y) - DW'(req_start_y);
         a_sh_ff <= a_sh_in;
         a_eh_ff <= a_eh_in;
      end
   end

   // ---------------- stage b: prescale, pre-rotation into right half plane
   logic                 b_v_ff;
   logic signed [CW-1:0] b_x_ff, b_y_ff, b_xs, b_ys;
   logic [SW-1:0]        b_side_ff;
   logic                 b_neg, b_zero;

   // cordic chain links, index 0 is stage b's output
   logic                 c_v   [N+1];
   logic                 c_rdy [N+1];
   logic signed [CW-1:0] c_x   [N+1];
   logic signed [CW-1:0] c_y   [N+1];
   angle_type            c_z   [N+1];
   logic [SW-1:0]        c_side[N+1];

   assign b_load = !b_v_ff || c_rdy[0];

   always_comb begin
      b_xs   = CW'(a_dx_ff) <<< PRESCALE_BITS;
      b_ys   = CW'(a_dy_ff) <<< PRESCALE_BITS;
      b_neg  = a_dx_ff[DW-1];
      b_zero = (a_dx_ff == '0) && (a_dy_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (b_load) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_load && a_v_ff) begin
         b_x_ff    <= b_neg ? -b_xs : b_xs;
         b_y_ff    <= b_neg ? -b_ys : b_ys;
         b_side_ff <= {b_neg, b_zero, a_sh_ff, a_eh_ff};
      end
   end

   assign c_v[0]    = b_v_ff;
   assign c_x[0]    = b_x_ff;
   assign c_y[0]    = b_y_ff;
   assign c_z[0]    = '0;
   assign c_side[0] = b_side_ff;

   // ---------------- cordic vectoring stages
   for (genvar i = 0; i < N; i++) begin : g_cordic
      hds_cordic_stage #(
         .W    (CW),
         .STEP (i),
         .SW   (SW)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_v[i]),
         .in_ready  (c_rdy[i]),
         .in_x      (c_x[i]),
         .in_y      (c_y[i]),
         .in_z      (c_z[i]),
         .in_side   (c_side[i]),
         .out_valid (c_v[i+1]),
         .out_ready (c_rdy[i+1]),
         .out_x     (c_x[i+1]),
         .out_y     (c_y[i+1]),
         .out_z     (c_z[i+1]),
         .out_side  (c_side[i+1])
      );
   end

   // ---------------- stage d: add back half a turn after pre-rotation
   logic          d_v_ff, d_load, e_load;
   angle_type     d_ang_ff;
   logic          d_zero_ff;
   logic [HB-1:0] d_sh_ff, d_eh_ff;

   assign d_load   = !d_v_ff || e_load;
   assign c_rdy[N] = d_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (d_load) begin
         d_v_ff <= c_v[N];
      end
   end

   always_ff @(posedge clock) begin
      if (d_load && c_v[N]) begin
         d_ang_ff  <= c_z[N] + (c_side[N][SW-1] ? HALF_TURN_Q32 : angle_type'(0));
         d_zero_ff <= c_side[N][SW-2];
         d_sh_ff   <= c_side[N][2*HB-1:HB];
         d_eh_ff   <= c_side[N][HB-1:0];
      end
   end

   // ---------------- stage e: wrap negative angle, add rounding half unit
   logic               e_v_ff, f_load;
   logic [ANGLE_W-1:0] e_pos_ff, e_wrap;
   logic               e_zero_ff;
   logic [HB-1:0]      e_sh_ff, e_eh_ff;

   assign e_load = !e_v_ff || f_load;
   assign e_wrap = d_ang_ff[ANGLE_W-1] ? FULL_TURN_Q32 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (e_load) begin
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (e_load && d_v_ff) begin
         e_pos_ff  <= d_ang_ff + e_wrap + ROUND_HALF;
         e_zero_ff <= d_zero_ff;
         e_sh_ff   <= d_sh_ff;
         e_eh_ff   <= d_eh_ff;
      end
   end

   // ---------------- stage f: bearing in heading units, full turn and coincident points to zero
   logic          f_v_ff, g_load;
   logic [HB:0]   f_raw;
   logic [HB-1:0] f_b_ff, f_b_in;
   logic [HB-1:0] f_sh_ff, f_eh_ff;

   assign f_load = !f_v_ff || g_load;
   assign f_raw  = e_pos_ff[ANGLE_W-1:RSH];

   always_comb begin
      if (e_zero_ff) begin
         f_b_in = '0;
      end else if (f_raw >= FULL_TURN) begin
         f_b_in = HB'(f_raw - FULL_TURN);
      end else begin
         f_b_in = HB'(f_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (f_load) begin
         f_v_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f_load && e_v_ff) begin
         f_b_ff  <= f_b_in;
         f_sh_ff <= e_sh_ff;
         f_eh_ff <= e_eh_ff;
      end
   end

   // ---------------- stage g: fold each deviation to the shorter way round
   logic          g_v_ff, h_load;
   logic [HB-1:0] g_ds_ff, g_de_ff, g_ds_in, g_de_in, g_abs_s, g_abs_e;

   assign g_load = !g_v_ff || h_load;

   always_comb begin
      g_abs_s = (f_sh_ff > f_b_ff) ? (f_sh_ff - f_b_ff) : (f_b_ff - f_sh_ff);
      g_abs_e = (f_eh_ff > f_b_ff) ? (f_eh_ff - f_b_ff) : (f_b_ff - f_eh_ff);
      g_ds_in = ({1'b0, g_abs_s} < HALF_TURN) ? g_abs_s
                                              : HB'(FULL_TURN - {1'b0, g_abs_s});
      g_de_in = ({1'b0, g_abs_e} < HALF_TURN) ? g_abs_e
                                              : HB'(FULL_TURN - {1'b0, g_abs_e});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (g_load) begin
         g_v_ff <= f_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (g_load && f_v_ff) begin
         g_ds_ff <= g_ds_in;
         g_de_ff <= g_de_in;
      end
   end

   // ---------------- stage h: output register with the sum
   logic          rsp_valid_ff;
   logic [HB-1:0] rsp_total_ff;

   assign h_load = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (h_load) begin
         rsp_valid_ff <= g_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (h_load && g_v_ff) begin
         rsp_total_ff <= g_ds_ff + g_de_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_total_deviation = rsp_total_ff;

   // ---------------- checks
   a_heading_reduced : assert property (@(posedge clock) disable iff (reset)
      a_v_ff |-> ({1'b0, a_sh_ff} < FULL_TURN) && ({1'b0, a_eh_ff} < FULL_TURN))
      else $error("reduced heading not below a full turn");

   a_bearing_range : assert property (@(posedge clock) disable iff (reset)
      f_v_ff |-> ({1'b0, f_b_ff} < FULL_TURN))
      else $error("bearing not below a full turn");

   a_fold_range : assert property (@(posedge clock) disable iff (reset)
      g_v_ff |-> ({1'b0, g_ds_ff} <= HALF_TURN) && ({1'b0, g_de_ff} <= HALF_TURN))
      else $error("folded deviation above half a turn");

   a_total_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({1'b0, rsp_total_ff} <= FULL_TURN))
      else $error("total deviation above a full turn");

   a_wrap_positive : assert property (@(posedge clock) disable iff (reset)
      e_v_ff |-> !e_pos_ff[ANGLE_W-1])
      else $error("wrapped angle still negative");

endmodule

/* verif/heading_deviation_sum_unit_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// heading_deviation_sum_unit_tb
// Self-checking bench for the heading deviation sum unit. Pose pairs go in
// on the req channel and the bench predicts each total deviation with its
// own cordic bearing model. Results on the rsp channel are checked in order.
// Directed words cover the special bearings and heading wrap cases. Random
// words follow, with random gaps on req, random stalls on rsp and one long
// full-rate stretch.
// ---------------------------------------------------------------------------
module heading_deviation_sum_unit_tb;

   localparam int POS_W   = hds_pkg::POS_BITS_DEF;
   localparam int FRAC_W  = hds_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int HEAD_W  = FRAC_W + hds_pkg::HEAD_INT_BITS;
   localparam int STEPS   = (hds_pkg::ATAN_STEPS_DEF > 32) ? 32 : hds_pkg::ATAN_STEPS_DEF;
   localparam int LATENCY = hds_pkg::ATAN_STEPS_DEF + 7;

   // angle formats of the bearing model
   localparam int     SCALE_SHIFT = 24;
   localparam longint ONE_DEG_Q32 = longint'(1) << 32;
   localparam longint FULL_UNITS  = longint'(360) << FRAC_W;
   localparam longint HALF_UNITS  = longint'(180) << FRAC_W;
   localparam int     HEAD_MAX    = 360 * (1 << FRAC_W) - 1;
   localparam int     HEAD_TOP    = (1 << HEAD_W) - 1;

   // run limit in clock cycles, far beyond the slowest correct run
   localparam int LIMIT_CYCLES = 150000;

   // atan(2^-i) in degrees with 32 fraction bits
   localparam longint ARCTAN_Q32 [32] = '{
      64'sd193273528320, 64'sd114096026022, 64'sd60285206653, 64'sd30601712202,
      64'sd15360239180,  64'sd7687607525,   64'sd3844741810,  64'sd1922488225,
      64'sd961258780,    64'sd480631223,    64'sd240315840,   64'sd120157949,
      64'sd60078978,     64'sd30039490,     64'sd15019745,    64'sd7509872,
      64'sd3754936,      64'sd1877468,      64'sd938734,      64'sd469367,
      64'sd234684,       64'sd117342,       64'sd58671,       64'sd29335,
      64'sd14668,        64'sd7334,         64'sd3667,        64'sd1833,
      64'sd917,          64'sd458,          64'sd229,         64'sd115
   };

   typedef logic signed [POS_W-1:0] coord_type;
   typedef logic [HEAD_W-1:0]       heading_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   coord_type   req_start_x;
   coord_type   req_start_y;
   heading_type req_start_heading;
   coord_type   req_end_x;
   coord_type   req_end_y;
   heading_type req_end_heading;
   logic        rsp_valid;
   logic        rsp_ready;
   heading_type rsp_total_deviation;

   // totals still owed by the unit, oldest first
   heading_type pending_totals [$];
   int          error_count;
   logic        jitter_on;

   heading_deviation_sum_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_x         (req_start_x),
      .req_start_y         (req_start_y),
      .req_start_heading   (req_start_heading),
      .req_end_x           (req_end_x),
      .req_end_y           (req_end_y),
      .req_end_heading     (req_end_heading),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_deviation (rsp_total_deviation)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // heading brought onto one turn
   function automatic longint wrap_heading(heading_type h);
      longint v;
      v = longint'(h);
      if (v >= FULL_UNITS) v -= FULL_UNITS;
      return v;
   endfunction

   // difference taken the shorter way round
   function automatic longint fold_deviation(longint h, longint b);
      longint d;
      d = (h > b) ? (h - b) : (b - h);
      return (d < HALF_UNITS) ? d : (FULL_UNITS - d);
   endfunction

   function automatic heading_type predict_total_deviation(
      coord_type sx, coord_type sy, heading_type sh,
      coord_type ex, coord_type ey, heading_type eh);
      longint dx, dy, x, y, xs, ys, z, ang, bearing;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      bearing = 0;
      // coincident points keep bearing zero
      if (dx != 0 || dy != 0) begin
         x = dx * (longint'(1) << SCALE_SHIFT);
         y = dy * (longint'(1) << SCALE_SHIFT);
         z = 0;
         ang = 0;
         // left half plane: turn the vector round and add half a turn
         if (x < 0) begin
            x = -x;
            y = -y;
            ang = 180 * ONE_DEG_Q32;
         end
         // vectoring steps drive y towards zero
         for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x += ys;
               y -= xs;
               z += ARCTAN_Q32[i];
            end else begin
               x -= ys;
               y += xs;
               z -= ARCTAN_Q32[i];
            end
         end
         ang += z;
         if (ang < 0) ang += 360 * ONE_DEG_Q32;
         // round to heading units, ties upwards, full turn back to zero
         bearing = ((ang << FRAC_W) + (longint'(1) << 31)) >>> 32;
         if (bearing >= FULL_UNITS) bearing -= FULL_UNITS;
      end
      return heading_type'(fold_deviation(wrap_heading(sh), bearing) +
                           fold_deviation(wrap_heading(eh), bearing));
   endfunction

   // one pose pair onto the req channel, with random gaps ahead of it
   task automatic send_pose_pair(coord_type sx, coord_type sy, heading_type sh,
                                 coord_type ex, coord_type ey, heading_type eh);
      while (jitter_on && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_start_x       <= sx;
      req_start_y       <= sy;
      req_start_heading <= sh;
      req_end_x         <= ex;
      req_end_y         <= ey;
      req_end_heading   <= eh;
      do @(posedge clock); while (!req_ready);
      pending_totals.push_back(predict_total_deviation(sx, sy, sh, ex, ey, eh));
   endtask

   // axis bearings, coincident points, corner to corner and rounding to a full turn
   task automatic test_special_bearings();
      send_pose_pair(100, -200, 0, 100, -200, 11520);
      send_pose_pair(-32768, -32768, HEAD_MAX, -32768, -32768, 1);
      send_pose_pair(0, 0, 0, 1000, 0, HEAD_MAX);
      send_pose_pair(500, 0, 11520, -500, 0, 0);
      send_pose_pair(0, -32768, 5760, 0, 32767, 17280);
      send_pose_pair(0, 32767, 17280, 0, -32768, 5760);
      send_pose_pair(-32768, 0, 0, 32767, -1, HEAD_MAX);
      send_pose_pair(0, 0, 11520, -32768, -1, 0);
      send_pose_pair(-32768, -32768, 2880, 32767, 32767, 14400);
      send_pose_pair(32767, 32767, 14400, -32768, -32768, 2880);
      send_pose_pair(0, 0, 100, 1, 1, 20000);
      send_pose_pair(0, 0, 8640, -1, 1, 8640);
      send_pose_pair(0, 0, 20160, 1, -1, 0);
      send_pose_pair(0, 0, 14400, -1, -1, 3000);
      send_pose_pair(32767, -32768, 7000, -32768, 32767, 9000);
   endtask

   // exact half turn, either side of it, and headings past a full turn
   task automatic test_heading_extremes();
      send_pose_pair(0, 0, 0, 10, 0, 11520);
      send_pose_pair(0, 0, 11519, 10, 0, 11521);
      send_pose_pair(0, 0, HEAD_MAX, 10, 0, 1);
      send_pose_pair(0, 0, 23040, 10, 0, HEAD_TOP);
      send_pose_pair(0, 0, HEAD_TOP, 10, 0, 23040);
      send_pose_pair(0, 0, 16384, 10, 0, 8191);
      send_pose_pair(-5, -5, 17280, -5, 5, 5760);
      send_pose_pair(5, 5, 0, -5, 5, 11520);
   endtask

   // random pose pairs; mostly spread wide, some close together or on an axis
   task automatic test_random_pairs(int count);
      int          kind, ax, ay;
      coord_type   sx, sy, ex, ey;
      heading_type sh, eh;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(9);
         sx = coord_type'($urandom);
         sy = coord_type'($urandom);
         ex = coord_type'($urandom);
         ey = coord_type'($urandom);
         if (kind >= 5 && kind <= 7) begin
            ax = int'($urandom_range(65520)) - 32760;
            ay = int'($urandom_range(65520)) - 32760;
            sx = coord_type'(ax);
            sy = coord_type'(ay);
            ex = coord_type'(ax + int'($urandom_range(16)) - 8);
            ey = coord_type'(ay + int'($urandom_range(16)) - 8);
         end else if (kind == 8) begin
            case ($urandom_range(2))
               0: begin ex = sx; ey = sy; end
               1: ey = sy;
               default: ex = sx;
            endcase
         end
         sh = heading_type'($urandom_range(HEAD_MAX));
         eh = heading_type'($urandom_range(HEAD_MAX));
         // headings near the turn boundaries, now and then past a full turn
         if (kind == 9) begin
            sh = heading_type'(($urandom_range(1) ? 11520 : HEAD_MAX) - $urandom_range(3));
            eh = heading_type'($urandom_range(3));
         end
         if ($urandom_range(7) == 0) sh = heading_type'($urandom_range(HEAD_TOP, 23040));
         if ($urandom_range(7) == 0) eh = heading_type'($urandom_range(HEAD_TOP, 23040));
         send_pose_pair(sx, sy, sh, ex, ey, eh);
      end
   endtask

   // a long run with no gaps and no stalls at all
   task automatic test_full_throughput();
      jitter_on <= 1'b0;
      test_random_pairs(250);
      jitter_on <= 1'b1;
   endtask

   // rsp stalls at random while jitter is on
   always @(posedge clock) begin
      rsp_ready <= !(jitter_on && $urandom_range(99) < 22);
   end

   // each accepted rsp word against the oldest owed total
   always @(posedge clock) begin
      heading_type expected_total;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_totals.size() == 0) begin
            error_count++;
            $error("total_deviation with nothing owed: expected none, actual %0d",
                   rsp_total_deviation);
         end else begin
            expected_total = pending_totals.pop_front();
            if (rsp_total_deviation !== expected_total) begin
               error_count++;
               $error("total_deviation mismatch: expected %0d, actual %0d",
                      expected_total, rsp_total_deviation);
            end
         end
      end
   end

   initial begin
      error_count = 0;
      reset             <= 1'b1;
      jitter_on         <= 1'b1;
      req_valid         <= 1'b0;
      req_start_x       <= '0;
      req_start_y       <= '0;
      req_start_heading <= '0;
      req_end_x         <= '0;
      req_end_y         <= '0;
      req_end_heading   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_special_bearings();
      test_heading_extremes();
      test_random_pairs(280);
      test_full_throughput();
      test_random_pairs(270);

      // drain what is still in flight
      req_valid <= 1'b0;
      jitter_on <= 1'b0;
      while (pending_totals.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_CYCLES * 12);
      $error("timeout with %0d totals still owed", pending_totals.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
